// ----- hw/rtl/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants
// Word formats, status codes, back-end state encoding and fixed widths used
// by the sample mean and spread block.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MEAN_W     = 24;
	localparam int SPREAD_W   = 24;
	localparam int USED_W     = 13;
	localparam int STATUS_W   = 2;

	localparam int MUL_CHUNK  = 16;
	localparam int SQRT_W     = 64;
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_CW    = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FEW   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd2;

	localparam logic [MEAN_W-1:0]   MEAN_POS_MAX = 24'h7F_FFFF;
	localparam logic [MEAN_W-1:0]   MEAN_NEG_MIN = 24'h80_0000;
	localparam logic [SPREAD_W-1:0] SPREAD_MAX   = 24'hFF_FFFF;
	localparam logic [SQRT_W-1:0]   SQRT_TOP     = 64'h4000_0000_0000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} msd_in_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean_value;
		logic [SPREAD_W-1:0]      spread_value;
		logic [USED_W-1:0]        samples_used;
		logic [STATUS_W-1:0]      status;
	} msd_out_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_GO,
		ST_MEAN,
		ST_MUL_NQ,
		ST_MUL_SS,
		ST_MUL_D1,
		ST_MUL_D2,
		ST_DIV_GO,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} msd_state_t;

endpackage

// ----- hw/rtl/msd_front.sv -----
// ----------------------------------------------------------------------------
// msd_front: sample accumulator
// Squares each sample in a first stage, then adds it into the count, sum and
// sum of squares. A last-marked word hands the totals to the set queue.
// ----------------------------------------------------------------------------
module msd_front import msd_pkg::*; #(
	parameter int MAX_COUNT = 4096,
	localparam int CNT_W = $clog2(MAX_COUNT + 1),
	localparam int SUM_W = CNT_W + SAMPLE_W,
	localparam int SQ_W  = CNT_W + 2 * SAMPLE_W - 2,
	localparam int ENT_W = 1 + CNT_W + SUM_W + SQ_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             smp_valid,
	output logic             smp_stall,
	input  msd_in_t          smp_data,
	input  q_stat_t          q_stat,
	output logic             push,
	output logic [ENT_W-1:0] entry
);

	localparam int SQR_W = 2 * SAMPLE_W - 1;

	logic                       valid_s1;
	logic                       last_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [SQR_W-1:0]           sqr_s1;
	logic signed [2*SAMPLE_W-1:0] sq_full;

	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic signed [SUM_W-1:0] sum_q, sum_d;
	logic [SQ_W-1:0]         sqs_q, sqs_d;
	logic                    lim_q, lim_d;
	logic                    blocked, accept, take;

	// a finished set waits in stage 1 until the queue has room
	assign blocked   = valid_s1 && last_s1 && q_stat.full;
	assign smp_stall = blocked;
	assign accept    = smp_valid && !blocked;
	assign sq_full   = smp_data.sample * smp_data.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!blocked) begin
			valid_s1 <= smp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= smp_data.sample;
			last_s1   <= smp_data.last;
			sqr_s1    <= sq_full[SQR_W-1:0];
		end
	end

	always_comb begin
		take  = cnt_q < CNT_W'(MAX_COUNT);
		cnt_d = take ? cnt_q + 1'b1 : cnt_q;
		sum_d = take ? sum_q + SUM_W'(sample_s1) : sum_q;
		sqs_d = take ? sqs_q + SQ_W'(sqr_s1) : sqs_q;
		lim_d = lim_q || !take;
	end

	assign push  = valid_s1 && last_s1 && !q_stat.full;
	assign entry = {lim_d, cnt_d, sum_d, sqs_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sqs_q <= '0;
			lim_q <= 1'b0;
		end else if (valid_s1 && !blocked) begin
			if (last_s1) begin
				cnt_q <= '0;
				sum_q <= '0;
				sqs_q <= '0;
				lim_q <= 1'b0;
			end else begin
				cnt_q <= cnt_d;
				sum_q <= sum_d;
				sqs_q <= sqs_d;
				lim_q <= lim_d;
			end
		end
	end

endmodule

// ----- hw/rtl/msd_queue.sv -----
// ----------------------------------------------------------------------------
// msd_queue: set queue
// Two-entry first-in first-out buffer of set totals between the accumulator
// and the arithmetic back end.
// ----------------------------------------------------------------------------
module msd_queue import msd_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output q_stat_t      q_stat
);

	logic [W-1:0]      mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/msd_divide.sv -----
// ----------------------------------------------------------------------------
// msd_divide: restoring divider
// Unsigned division, one quotient bit per cycle, shared by the mean and the
// spread computations.
// ----------------------------------------------------------------------------
module msd_divide import msd_pkg::*; #(
	parameter int DW = 64,
	parameter int VW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output div_stat_t     div_stat,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [VW:0]   trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	assign quotient      = quo_q;
	assign remainder     = rem_q;
	assign div_stat.busy = busy_q;
	assign div_stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == CW'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

endmodule

// ----- hw/rtl/msd_back.sv -----
// ----------------------------------------------------------------------------
// msd_back: per-set arithmetic
// Takes one set of totals from the queue and works out the floored mean,
// the exact variance numerator and divisor on a chunked multiplier, the
// quotient on the shared divider and the floored square root.
// ----------------------------------------------------------------------------
module msd_back import msd_pkg::*; #(
	parameter int MAX_COUNT = 4096,
	parameter int FRAC_BITS = 8,
	localparam int CNT_W = $clog2(MAX_COUNT + 1),
	localparam int SUM_W = CNT_W + SAMPLE_W,
	localparam int SQ_W  = CNT_W + 2 * SAMPLE_W - 2,
	localparam int ENT_W = 1 + CNT_W + SUM_W + SQ_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mode,
	input  logic [ENT_W-1:0] entry,
	input  q_stat_t          q_stat,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output msd_out_t         res_data
);

	localparam int AW  = CNT_W + SAMPLE_W - 1;
	localparam int BW  = SQ_W;
	localparam int PW  = AW + BW;
	localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BPW = NCH * MUL_CHUNK;
	localparam int MCW = $clog2(NCH);
	localparam int VW  = 3 * CNT_W;
	localparam int DW  = PW + 2 * FRAC_BITS;
	localparam int MW  = DW + 1;
	localparam int QPW = (DW > SQRT_W) ? DW : SQRT_W;

	msd_state_t state_q, state_d;

	// set totals
	logic [CNT_W-1:0]        n_q;
	logic                    s_neg_q;
	logic [AW-1:0]           s_mag_q;
	logic [SQ_W-1:0]         qs_q;
	logic                    lim_q;
	logic [CNT_W-1:0]        n_e;
	logic signed [SUM_W-1:0] s_e;
	logic [SUM_W-1:0]        s_abs_e;

	// multiplier
	logic [AW-1:0]           mul_a_q, mul_a_d;
	logic [BPW-1:0]          mul_b_q;
	logic [BW-1:0]           mul_b_d;
	logic [PW-1:0]           mul_acc_q, mul_acc_d;
	logic [AW+MUL_CHUNK-1:0] mul_pp;
	logic [MCW-1:0]          mul_cnt_q;
	logic                    mul_load, mul_run, mul_last;

	// divider
	logic          div_start;
	logic [DW-1:0] div_dvd, mean_dvd, spread_dvd;
	logic [VW-1:0] div_dvs;
	logic [DW-1:0] div_quo;
	logic [VW-1:0] div_rem;
	div_stat_t     div_stat;
	logic [QPW-1:0] quo_pad;

	// mean
	logic [MW-1:0]     mean_mag;
	logic [MEAN_W-1:0] mag_lo, mean_d, mean_q;

	// spread
	logic [PW-1:0]       dev_q;
	logic [VW-1:0]       den_q;
	logic [SQRT_W-1:0]   sq_x_q, sq_res_q, sq_bit_q, sq_t, sq_res_d;
	logic                sq_ge, sq_last;
	logic [SQRT_CW-1:0]  sq_cnt_q;
	logic [SPREAD_W-1:0] spread_q, spread_sat;

	// output
	msd_out_t            out_q;
	logic                out_valid_q, out_load;
	logic [STATUS_W-1:0] status_d;

	assign n_e     = entry[SQ_W+SUM_W +: CNT_W];
	assign s_e     = entry[SQ_W +: SUM_W];
	assign s_abs_e = s_e[SUM_W-1] ? -s_e : s_e;

	// ---- chunked multiplier, top chunk of b first
	assign mul_pp    = mul_a_q * mul_b_q[BPW-1 -: MUL_CHUNK];
	assign mul_acc_d = (mul_acc_q << MUL_CHUNK) + PW'(mul_pp);
	assign mul_last  = mul_cnt_q == MCW'(NCH - 1);
	assign mul_run   = state_q == ST_MUL_NQ || state_q == ST_MUL_SS ||
		state_q == ST_MUL_D1 || state_q == ST_MUL_D2;

	// ---- divider operands
	assign mean_dvd   = DW'(s_mag_q) << FRAC_BITS;
	assign spread_dvd = DW'(dev_q) << (2 * FRAC_BITS);
	assign div_dvd    = (state_q == ST_MEAN_GO) ? mean_dvd : spread_dvd;
	assign div_dvs    = (state_q == ST_MEAN_GO) ? VW'(n_q) : den_q;
	assign quo_pad    = QPW'(div_quo);

	msd_divide #(
		.DW(DW),
		.VW(VW)
	) u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.div_stat (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// ---- floored mean with saturation
	always_comb begin
		mean_mag = MW'(div_quo) + MW'(s_neg_q && div_rem != '0);
		mag_lo   = mean_mag[MEAN_W-1:0];
		if (n_q == '0) begin
			mean_d = '0;
		end else if (!s_neg_q && mean_mag > MW'(MEAN_POS_MAX)) begin
			mean_d = MEAN_POS_MAX;
		end else if (s_neg_q && mean_mag > MW'(MEAN_NEG_MIN)) begin
			mean_d = MEAN_NEG_MIN;
		end else begin
			mean_d = s_neg_q ? ~mag_lo + 1'b1 : mag_lo;
		end
	end

	// ---- square root, one result bit per cycle
	always_comb begin
		sq_t       = sq_res_q + sq_bit_q;
		sq_ge      = sq_x_q >= sq_t;
		sq_res_d   = sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;
		sq_last    = sq_cnt_q == SQRT_CW'(SQRT_STEPS - 1);
		spread_sat = (sq_res_d > SQRT_W'(SPREAD_MAX)) ? SPREAD_MAX : SPREAD_W'(sq_res_d);
	end

	always_comb begin
		if (lim_q) begin
			status_d = STAT_LIMIT;
		end else if (n_q < CNT_W'(2)) begin
			status_d = STAT_FEW;
		end else begin
			status_d = STAT_OK;
		end
	end

	// ---- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		mul_load  = 1'b0;
		mul_a_d   = '0;
		mul_b_d   = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: begin
				div_start = 1'b1;
				state_d   = ST_MEAN;
			end
			ST_MEAN: begin
				if (div_stat.done) begin
					if (n_q < CNT_W'(2)) begin
						state_d = ST_DONE;
					end else begin
						state_d  = ST_MUL_NQ;
						mul_load = 1'b1;
						mul_a_d  = AW'(n_q);
						mul_b_d  = qs_q;
					end
				end
			end
			ST_MUL_NQ: begin
				if (mul_last) begin
					state_d  = ST_MUL_SS;
					mul_load = 1'b1;
					mul_a_d  = s_mag_q;
					mul_b_d  = BW'(s_mag_q);
				end
			end
			ST_MUL_SS: begin
				if (mul_last) begin
					state_d  = ST_MUL_D1;
					mul_load = 1'b1;
					mul_a_d  = AW'(n_q - CNT_W'(1));
					mul_b_d  = BW'(n_q);
				end
			end
			ST_MUL_D1: begin
				if (mul_last) begin
					if (mode) begin
						state_d  = ST_MUL_D2;
						mul_load = 1'b1;
						mul_a_d  = AW'(n_q);
						mul_b_d  = BW'(mul_acc_d);
					end else begin
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_MUL_D2: begin
				if (mul_last) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sq_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- counters and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q   <= '0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_load) begin
				mul_cnt_q <= '0;
			end else if (mul_run) begin
				mul_cnt_q <= mul_cnt_q + 1'b1;
			end
			if (state_q == ST_DIV) begin
				sq_cnt_q <= '0;
			end else if (state_q == ST_SQRT) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			n_q     <= n_e;
			s_neg_q <= s_e[SUM_W-1];
			s_mag_q <= AW'(s_abs_e);
			qs_q    <= entry[SQ_W-1:0];
			lim_q   <= entry[ENT_W-1];
		end

		if (mul_load) begin
			mul_a_q   <= mul_a_d;
			mul_b_q   <= BPW'(mul_b_d);
			mul_acc_q <= '0;
		end else if (mul_run) begin
			mul_acc_q <= mul_acc_d;
			mul_b_q   <= mul_b_q << MUL_CHUNK;
		end

		if (state_q == ST_MEAN && div_stat.done) begin
			mean_q   <= mean_d;
			spread_q <= '0;
		end

		if (mul_last) begin
			unique case (state_q)
				ST_MUL_NQ: begin
					dev_q <= mul_acc_d;
				end
				ST_MUL_SS: begin
					dev_q <= dev_q - mul_acc_d;
				end
				ST_MUL_D1, ST_MUL_D2: begin
					den_q <= VW'(mul_acc_d);
				end
				default: begin
				end
			endcase
		end

		if (state_q == ST_DIV && div_stat.done) begin
			sq_x_q   <= quo_pad[SQRT_W-1:0];
			sq_res_q <= '0;
			sq_bit_q <= SQRT_TOP;
		end else if (state_q == ST_SQRT) begin
			if (sq_ge) begin
				sq_x_q <= sq_x_q - sq_t;
			end
			sq_res_q <= sq_res_d;
			sq_bit_q <= sq_bit_q >> 2;
			if (sq_last) begin
				spread_q <= spread_sat;
			end
		end

		if (out_load) begin
			out_q.mean_value   <= mean_q;
			out_q.spread_value <= spread_q;
			out_q.samples_used <= USED_W'(n_q);
			out_q.status       <= status_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

// ----- hw/rtl/mean_and_std_deviation_top.sv -----
// ----------------------------------------------------------------------------
// mean_and_std_deviation_top: sample mean and standard deviation
// Accumulates signed samples per set and reports the floored mean and the
// floored sample standard deviation or standard error in fixed point.
// ----------------------------------------------------------------------------
//  channel | signals                          | word
//  --------+----------------------------------+-------------------------------
//  samples | smp_valid, smp_stall, smp_data   | msd_in_t: sample, last
//  results | res_valid, res_stall, res_data   | msd_out_t: mean, spread, n, status
//  config  | cfg_valid, cfg_ready, cfg_data   | spread mode bit
//
//  one sample per cycle unless stalled; a set's last word is pushed from stage 1
//  once the queue has room; back end: one set at a time, paced by the one-bit
//  divider and the square root loop, with one more multiplier pass in error
//  mode; sets under two samples stop after the mean division
//  two finished sets can queue; samples stall only when a third set ends
//  reset clears the accumulators, the queue, the sequencer and the mode
// ----------------------------------------------------------------------------
module mean_and_std_deviation_top import msd_pkg::*; #(
	parameter int MAX_COUNT = 4096,
	parameter int FRAC_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     smp_valid,
	output logic     smp_stall,
	input  msd_in_t  smp_data,
	output logic     res_valid,
	input  logic     res_stall,
	output msd_out_t res_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	localparam int CNT_W = $clog2(MAX_COUNT + 1);
	localparam int SUM_W = CNT_W + SAMPLE_W;
	localparam int SQ_W  = CNT_W + 2 * SAMPLE_W - 2;
	localparam int ENT_W = 1 + CNT_W + SUM_W + SQ_W;

	logic             mode_q;
	logic             push, pop;
	logic [ENT_W-1:0] wr_entry, rd_entry;
	q_stat_t          q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	msd_front #(
		.MAX_COUNT(MAX_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.smp_data (smp_data),
		.q_stat   (q_stat),
		.push     (push),
		.entry    (wr_entry)
	);

	msd_queue #(
		.W(ENT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_entry),
		.pop    (pop),
		.rd_data(rd_entry),
		.q_stat (q_stat)
	);

	msd_back #(
		.MAX_COUNT(MAX_COUNT),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.entry    (rd_entry),
		.q_stat   (q_stat),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	// samples are held back only by a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		smp_stall |-> q_stat.full)
		else $error("sample stall without a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_few_spread: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status == STAT_FEW |-> res_data.spread_value == '0)
		else $error("nonzero spread with fewer than two samples");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("set pushed into a full queue");

endmodule
